// File: src/sida_pkg.sv
package sida_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_CNT_W = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for every 32-bit n
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

    // one converted value: digits[0] is the most significant digit
    typedef struct packed {
        logic                   neg;
        logic [DIGIT_CNT_W-1:0] cnt;
        digit_vec_t             digits;
    } sida_rec_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_DIV,
        FRONT_PUSH
    } front_state_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_DIGITS
    } back_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        return CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    endfunction

endpackage

// File: src/sida_front.sv
module sida_front
    import sida_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,     // [31:0] value
    output logic               push_valid,
    input  logic               push_ready,
    output sida_rec_t          push_rec
);

    front_state_t           state_reg, state_next;
    logic [VALUE_W-1:0]     mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [DIGIT_CNT_W-1:0] cnt_reg, cnt_next;
    digit_vec_t             digits_reg, digits_next;

    logic [2*VALUE_W-1:0]   prod;
    logic [VALUE_W-1:0]     quot;
    logic [VALUE_W-1:0]     quot_x10;
    logic [VALUE_W-1:0]     rem_full;
    logic [DIGIT_W-1:0]     rem;
    digit_vec_t             digits_shift;
    logic [DIGIT_CNT_W-1:0] cnt_inc;

    // divide by ten via reciprocal multiply
    assign prod         = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP_TEN};
    assign quot         = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
    assign quot_x10     = (quot << 3) + (quot << 1);
    assign rem_full     = mag_reg - quot_x10;
    assign rem          = rem_full[DIGIT_W-1:0];
    assign digits_shift = {digits_reg[MAX_DIGITS-2:0], rem};
    assign cnt_inc      = cnt_reg + DIGIT_CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FRONT_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        digits_reg <= digits_next;
    end

    always_comb begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        digits_next     = digits_reg;
        s_tready        = 1'b0;
        push_valid      = 1'b0;
        push_rec.neg    = neg_reg;
        push_rec.cnt    = cnt_reg;
        push_rec.digits = digits_reg;
        case (state_reg)
            FRONT_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    neg_next    = s_tdata[VALUE_W-1];
                    mag_next    = s_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_tdata) : s_tdata;
                    cnt_next    = '0;
                    digits_next = '0;
                    state_next  = FRONT_DIV;
                end
            end
            FRONT_DIV: begin
                mag_next    = quot;
                cnt_next    = cnt_inc;
                digits_next = digits_shift;
                if (quot == '0) begin
                    push_valid      = 1'b1;
                    push_rec.cnt    = cnt_inc;
                    push_rec.digits = digits_shift;
                    state_next      = push_ready ? FRONT_IDLE : FRONT_PUSH;
                end
            end
            FRONT_PUSH: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    state_next = FRONT_IDLE;
                end
            end
            default: begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

endmodule

// File: src/sida_queue.sv
module sida_queue
    import sida_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  sida_rec_t push_rec,
    output logic      pop_valid,
    input  logic      pop_ready,
    output sida_rec_t pop_rec
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sida_rec_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// File: src/sida_back.sv
module sida_back
    import sida_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  sida_rec_t         pop_rec,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,    // [7:0] character
    output logic              m_tlast     // last
);

    back_state_t            state_reg, state_next;
    digit_vec_t             digits_reg, digits_next;
    logic [DIGIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]      m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;
    logic                   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BACK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        digits_reg <= digits_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        digits_next  = digits_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        pop_ready    = 1'b0;
        case (state_reg)
            BACK_IDLE: begin
                pop_ready = out_free;
                if (pop_valid && out_free) begin
                    m_valid_next = 1'b1;
                    if (pop_rec.neg) begin
                        m_data_next = CHAR_MINUS;
                        m_last_next = 1'b0;
                        digits_next = pop_rec.digits;
                        cnt_next    = pop_rec.cnt;
                        state_next  = BACK_DIGITS;
                    end else begin
                        m_data_next = digit_char(pop_rec.digits[0]);
                        m_last_next = (pop_rec.cnt == DIGIT_CNT_W'(1));
                        digits_next = {{DIGIT_W{1'b0}}, pop_rec.digits[MAX_DIGITS-1:1]};
                        cnt_next    = pop_rec.cnt - DIGIT_CNT_W'(1);
                        state_next  = (pop_rec.cnt == DIGIT_CNT_W'(1)) ? BACK_IDLE
                                                                       : BACK_DIGITS;
                    end
                end
            end
            BACK_DIGITS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = digit_char(digits_reg[0]);
                    m_last_next  = (cnt_reg == DIGIT_CNT_W'(1));
                    digits_next  = {{DIGIT_W{1'b0}}, digits_reg[MAX_DIGITS-1:1]};
                    cnt_next     = cnt_reg - DIGIT_CNT_W'(1);
                    if (cnt_reg == DIGIT_CNT_W'(1)) begin
                        state_next = BACK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BACK_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == CHAR_MINUS) || (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE))
        else $error("character outside sign and digit set");

    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata == CHAR_MINUS) |-> !m_tlast)
        else $error("minus sign flagged as last beat");

    a_run_unbroken: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside a run of characters");

    a_digits_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BACK_DIGITS) |-> (cnt_reg != '0))
        else $error("digit state with no digits left");
`endif

endmodule

// File: src/signed_int_to_decimal_ascii_core.sv
// channel | dir | tdata                 | tlast
// s_      | in  | [31:0] value (signed) | -
// m_      | out | [7:0] character       | last character of the value
//
// front: takes a value only when idle, then makes one decimal digit per cycle
// in the divide-by-ten loop and waits for the queue before the next value
// back: one beat per character, an optional '-' plus one to ten digits
// a queue of QUEUE_DEPTH converted values lets either side stall alone
// reset is synchronous on aresetn, clears all handshakes and the queue
module signed_int_to_decimal_ascii_core
    import sida_pkg::*;
#(
    parameter int QUEUE_DEPTH = sida_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CHAR_W-1:0]  m_tdata,   // [7:0] character
    output logic               m_tlast    // last
);

    logic      push_valid;
    logic      push_ready;
    sida_rec_t push_rec;
    logic      pop_valid;
    logic      pop_ready;
    sida_rec_t pop_rec;

    sida_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    sida_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    sida_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_rec   (pop_rec),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
